// File: hdl/u8d_pkg.sv
// shared types and constants for the utf-8 byte stream decoder
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned PEND_W   = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [BYTE_W-1:0] LEAD1_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hdf;
  localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hef;
  localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hf7;
  localparam logic [BYTE_W-1:0] MASK1       = 8'h7f;
  localparam logic [BYTE_W-1:0] MASK2       = 8'h1f;
  localparam logic [BYTE_W-1:0] MASK3       = 8'h0f;
  localparam logic [BYTE_W-1:0] MASK4       = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_CONT   = 8'h3f;

  // decoder state carried between bytes
  typedef struct packed {
    logic [CP_W-1:0]   partial_value;
    logic [PEND_W-1:0] bytes_pending;
    logic              error_seen;
  } u8d_state_t;

  // one result request
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            point_valid;
    logic            string_done;
    logic            string_ok;
  } u8d_res_t;

endpackage

// File: hdl/u8d_decode.sv
// decode state registers and the per-byte decode step
`timescale 1ns / 1ps

module u8d_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
  input  logic                       last_in,
  output logic                       res_present,
  output u8d_pkg::u8d_res_t          res
);

  u8d_pkg::u8d_state_t st_r, st_nxt;

  logic [u8d_pkg::CP_W-1:0]   shifted;
  logic [u8d_pkg::PEND_W-1:0] pend_dec;
  logic                       have_point;
  logic [u8d_pkg::CP_W-1:0]   point;

  assign shifted  = {st_r.partial_value[u8d_pkg::CP_W-7:0],
                     byte_in[5:0] & u8d_pkg::MASK_CONT[5:0]};
  assign pend_dec = st_r.bytes_pending - u8d_pkg::PEND_W'(1);

  always_comb begin
    st_nxt     = st_r;
    have_point = 1'b0;
    point      = '0;
    if (!st_r.error_seen) begin
      if (st_r.bytes_pending == '0) begin
        priority if (byte_in < u8d_pkg::LEAD1_LIMIT) begin
          point      = u8d_pkg::CP_W'(byte_in & u8d_pkg::MASK1);
          have_point = 1'b1;
        end else if (byte_in <= u8d_pkg::LEAD2_MAX) begin
          st_nxt.partial_value = u8d_pkg::CP_W'(byte_in & u8d_pkg::MASK2);
          st_nxt.bytes_pending = u8d_pkg::PEND_W'(1);
        end else if (byte_in <= u8d_pkg::LEAD3_MAX) begin
          st_nxt.partial_value = u8d_pkg::CP_W'(byte_in & u8d_pkg::MASK3);
          st_nxt.bytes_pending = u8d_pkg::PEND_W'(2);
        end else if (byte_in <= u8d_pkg::LEAD4_MAX) begin
          st_nxt.partial_value = u8d_pkg::CP_W'(byte_in & u8d_pkg::MASK4);
          st_nxt.bytes_pending = u8d_pkg::PEND_W'(3);
        end else begin
          st_nxt.error_seen = 1'b1;
        end
      end else begin
        st_nxt.bytes_pending = pend_dec;
        if (pend_dec == '0) begin
          point                = shifted;
          have_point           = 1'b1;
          st_nxt.partial_value = '0;
        end else begin
          st_nxt.partial_value = shifted;
        end
      end
      // string ends in the middle of a sequence
      if (last_in && (st_nxt.bytes_pending != '0)) begin
        st_nxt.error_seen = 1'b1;
      end
    end
    res.code_point  = point;
    res.point_valid = have_point;
    res.string_done = last_in;
    res.string_ok   = last_in && !st_nxt.error_seen;
    res_present     = have_point || last_in;
    if (last_in) begin
      st_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: hdl/u8d_out_reg.sv
// result register feeding the output stream
`timescale 1ns / 1ps

module u8d_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  u8d_pkg::u8d_res_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output u8d_pkg::u8d_res_t res_out
);

  logic              vld_r, vld_nxt;
  u8d_pkg::u8d_res_t res_r;

  assign can_load  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: hdl/utf8_byte_stream_decoder.sv
// top level: input register, decode step and result register
// path: an accepted byte waits in the input register, and its result in the result register that drives the output
// throughput: one byte per cycle while the result register can take a result; a byte that completes no code point and
// does not end its string leaves no result and takes no output slot
// reset: synchronous active-low rst_n clears both valid flags and the
// decode state (partial value, pending count, error flag)
`timescale 1ns / 1ps

module utf8_byte_stream_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [u8d_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,   // last_in_string
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [u8d_pkg::OUT_DATA_W-1:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [u8d_pkg::OUT_USER_W-1:0] out_tuser,  // [0] point_valid, [1] string_ok
  output logic                           out_tlast   // string_done
);

  logic                       in_vld_r, in_vld_nxt;
  logic [u8d_pkg::BYTE_W-1:0] in_byte_r;
  logic                       in_last_r;

  logic              res_present;
  u8d_pkg::u8d_res_t res_dec;
  u8d_pkg::u8d_res_t res_q;
  logic              can_load;
  logic              advance;
  logic              in_acc;

  // a byte without a result moves on regardless of the output side
  assign advance   = in_vld_r && (can_load || !res_present);
  assign in_tready = !in_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  u8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .byte_in     (in_byte_r),
    .last_in     (in_last_r),
    .res_present (res_present),
    .res         (res_dec)
  );

  u8d_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_present),
    .res_in    (res_dec),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {{(u8d_pkg::OUT_DATA_W - u8d_pkg::CP_W){1'b0}}, res_q.code_point};
  assign out_tuser = {res_q.string_ok, res_q.point_valid};
  assign out_tlast = res_q.string_done;

endmodule

// File: tb/sv/utf8_stream_checker.sv
// watches both channels of the utf-8 decoder, predicts each result and compares
`timescale 1ns / 1ps

module utf8_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [u8d_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,   // last_in_string
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [u8d_pkg::OUT_DATA_W-1:0] out_tdata,  // [20:0] code_point, [23:21] zero
  input  logic [u8d_pkg::OUT_USER_W-1:0] out_tuser,  // [0] point_valid, [1] string_ok
  input  logic                           out_tlast,  // string_done
  output int                             mismatches,
  output int                             results_outstanding
);

  u8d_pkg::u8d_state_t dec_state;
  u8d_pkg::u8d_res_t   predicted_results[$];
  u8d_pkg::u8d_res_t   got;
  u8d_pkg::u8d_res_t   want;
  u8d_pkg::u8d_res_t   fresh;
  int                  error_total;

  // one byte through the decoder state; returns 1 when the byte yields a result
  function automatic logic decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b,
                                       input logic last,
                                       output u8d_pkg::u8d_res_t res);
    logic                     has_point;
    logic [u8d_pkg::CP_W-1:0] point;
    has_point = 1'b0;
    point     = '0;
    res       = '0;
    if (!dec_state.error_seen) begin
      if (dec_state.bytes_pending == 0) begin
        if (b < u8d_pkg::LEAD1_LIMIT) begin
          point     = u8d_pkg::CP_W'(b & u8d_pkg::MASK1);
          has_point = 1'b1;
        end else if (b <= u8d_pkg::LEAD2_MAX) begin
          dec_state.partial_value = u8d_pkg::CP_W'(b & u8d_pkg::MASK2);
          dec_state.bytes_pending = 2'd1;
        end else if (b <= u8d_pkg::LEAD3_MAX) begin
          dec_state.partial_value = u8d_pkg::CP_W'(b & u8d_pkg::MASK3);
          dec_state.bytes_pending = 2'd2;
        end else if (b <= u8d_pkg::LEAD4_MAX) begin
          dec_state.partial_value = u8d_pkg::CP_W'(b & u8d_pkg::MASK4);
          dec_state.bytes_pending = 2'd3;
        end else begin
          dec_state.error_seen = 1'b1;
        end
      end else begin
        // continuation byte: its top bits are not looked at
        dec_state.partial_value = {dec_state.partial_value[u8d_pkg::CP_W-7:0], b[5:0]};
        dec_state.bytes_pending = dec_state.bytes_pending - 2'd1;
        if (dec_state.bytes_pending == 0) begin
          point                   = dec_state.partial_value;
          has_point               = 1'b1;
          dec_state.partial_value = '0;
        end
      end
      if (last && dec_state.bytes_pending != 0) dec_state.error_seen = 1'b1;
    end
    if (!has_point && !last) return 1'b0;
    res.code_point  = has_point ? point : '0;
    res.point_valid = has_point;
    res.string_done = last;
    res.string_ok   = last && !dec_state.error_seen;
    if (last) dec_state = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_state = '0;
      predicted_results.delete();
      error_total = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.code_point  = out_tdata[u8d_pkg::CP_W-1:0];
        got.point_valid = out_tuser[0];
        got.string_ok   = out_tuser[1];
        got.string_done = out_tlast;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result request: expected none, actual tdata %h",
                   $time, out_tdata);
          $display("%0t:   actual tuser %b tlast %b", $time, out_tuser, out_tlast);
          error_total++;
        end else begin
          want = predicted_results.pop_front();
          if (got.code_point != want.code_point) begin
            $display("%0t: code_point expected %h actual %h", $time, want.code_point,
                     got.code_point);
            error_total++;
          end
          if (got.point_valid != want.point_valid) begin
            $display("%0t: point_valid expected %b actual %b", $time, want.point_valid,
                     got.point_valid);
            error_total++;
          end
          if (got.string_done != want.string_done) begin
            $display("%0t: string_done expected %b actual %b", $time, want.string_done,
                     got.string_done);
            error_total++;
          end
          if (got.string_ok != want.string_ok) begin
            $display("%0t: string_ok expected %b actual %b", $time, want.string_ok,
                     got.string_ok);
            error_total++;
          end
          if (out_tdata[u8d_pkg::OUT_DATA_W-1:u8d_pkg::CP_W] != '0) begin
            $display("%0t: tdata pad bits expected 0 actual %b", $time,
                     out_tdata[u8d_pkg::OUT_DATA_W-1:u8d_pkg::CP_W]);
            error_total++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_byte(in_tdata, in_tlast, fresh)) begin
          predicted_results = {predicted_results, fresh};
        end
      end
    end
    mismatches          <= error_total;
    results_outstanding <= predicted_results.size();
  end

endmodule

// File: tb/sv/utf8_byte_stream_decoder_test.sv
// testbench top for the utf-8 decoder: clock, reset, byte strings and the verdict
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_test;

  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_EVERY  = 400;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [u8d_pkg::BYTE_W-1:0]     in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready = 1'b1;
  logic [u8d_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [u8d_pkg::OUT_USER_W-1:0] out_tuser;
  logic                           out_tlast;

  int          mismatches;
  int          results_outstanding;
  int          cycle_count = 0;
  int          burst_left;
  int          bytes_sent;
  int          next_drain;
  int          kind;
  int          cls;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_hold = 50;
  logic [7:0]  str_bytes[$];

  utf8_byte_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_stream_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tlast            (in_tlast),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .out_tlast           (out_tlast),
    .mismatches          (mismatches),
    .results_outstanding (results_outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure: a mode held for a random stretch of cycles
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(20, 300);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ~out_tready;
    endcase
  end

  // one request on the input channel, with bursts and random gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    str_bytes = {str_bytes, b};
  endfunction

  function automatic void add_lead(input int c);
    case (c)
      0:       append_byte(8'($urandom_range(8'h00, 8'h7f)));
      // stray 0x80..0xbf leads decode as two-byte leads
      1:       append_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h80, 8'hbf))
                                                       : 8'($urandom_range(8'hc0, 8'hdf)));
      2:       append_byte(8'($urandom_range(8'he0, 8'hef)));
      default: append_byte(8'($urandom_range(8'hf0, 8'hf7)));
    endcase
  endfunction

  function automatic void add_cont();
    if ($urandom_range(0, 7) == 0) append_byte(8'($urandom_range(0, 255)));
    else append_byte({2'b10, 6'($urandom)});
  endfunction

  function automatic void add_point();
    int c;
    c = $urandom_range(0, 3);
    add_lead(c);
    repeat (c) add_cont();
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    burst_left  = 0;
    bytes_sent  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of each lead class
    send_byte(8'h00, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hbf, 1'b1);
    send_byte(8'hdf, 1'b0);
    send_byte(8'hbf, 1'b1);
    send_byte(8'he0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b1);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    // unchecked continuation bits give the largest code point
    send_byte(8'hf7, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    // invalid lead, then a dropped byte
    send_byte(8'hf8, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hff, 1'b1);
    // sequence cut short, and a lead as the final byte
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hc3, 1'b1);
    drain();

    bytes_sent = 0;
    next_drain = DRAIN_EVERY;
    while (bytes_sent < RANDOM_BYTES) begin
      str_bytes.delete();
      kind = $urandom_range(0, 99);
      repeat ($urandom_range(0, 5)) add_point();
      if (kind < 70) begin
        add_point();
      end else if (kind < 82) begin
        cls = $urandom_range(1, 3);
        add_lead(cls);
        repeat ($urandom_range(0, cls - 1)) add_cont();
      end else if (kind < 92) begin
        append_byte(8'($urandom_range(8'hf8, 8'hff)));
        repeat ($urandom_range(0, 4)) append_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
      end
      send_string();
      if (bytes_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
